/* rtl/core/brd_pkg.sv */
// ----------------------------------------------------------------------------
// brd_pkg
// Shared types and constants of the byte run-length decoder.
// ----------------------------------------------------------------------------
package brd_pkg;

  localparam int unsigned LimitW         = 24;
  localparam int unsigned BytesPerResult = 4;
  localparam int unsigned WordW          = 8 * BytesPerResult;
  localparam int unsigned CountW         = 3;
  localparam int unsigned LenW           = 8;

  localparam logic [LimitW-1:0] LimitReset = {LimitW{1'b1}};

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } brd_in_t;

  typedef struct packed {
    logic [WordW-1:0]  out_word;
    logic [CountW-1:0] out_count;
    logic              item_last;
    logic              chunk_done;
    logic              status;
  } brd_out_t;

  // One unit of work for the back end: len copies of data_byte, len 0 for
  // a status-only word.
  typedef struct packed {
    logic [7:0]      data_byte;
    logic [LenW-1:0] len;
    logic            last;
    logic            status;
  } brd_cmd_t;

endpackage

/* rtl/core/byte_rle_decoder.sv */
// ----------------------------------------------------------------------------
// byte_rle_decoder
// Byte run-length decoder with per-chunk output limit.
// ----------------------------------------------------------------------------
// Header and literal bytes are taken one per cycle. A literal byte gives one
// word, a run of n bytes gives ceil(n/4) words, one per cycle from the
// expander when not stalled, so a run byte gives up to 32 words; the input
// stalls once the command queue (QUEUE_DEPTH entries) between parser and
// expander is full. The limit register takes effect from the chunk after the
// one in progress when it is written and the write port is always ready.
// ----------------------------------------------------------------------------
module byte_rle_decoder import brd_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  brd_in_t           in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output brd_out_t          out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [LimitW-1:0] cfg_data_i
);

  logic [LimitW-1:0] limit_q;
  logic              accept;
  logic              push;
  logic              full;
  logic              empty;
  logic              pop;
  brd_cmd_t          push_cmd;
  brd_cmd_t          head_cmd;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = full;
  assign accept      = in_valid_i && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      limit_q <= cfg_data_i;
    end
  end

  brd_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_data_i (in_data_i),
    .limit_i   (limit_q),
    .push_o    (push),
    .cmd_o     (push_cmd)
  );

  brd_queue #(
    .DataW ( 1 * $bits(brd_cmd_t)),
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (head_cmd)
  );

  brd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!empty),
    .cmd_i       (head_cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

`ifndef NO_ASSERTIONS
  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.out_count <= CountW'(BytesPerResult))
    else $error("word count above bytes per word");

  a_partial_final : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.item_last) |->
      out_data_o.out_count == CountW'(BytesPerResult))
    else $error("short word before the end of a byte's output");

  a_status_only : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.out_count == '0) |->
      (out_data_o.chunk_done && out_data_o.item_last))
    else $error("empty word that does not close the chunk");

  a_done_is_final : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.chunk_done) |-> out_data_o.item_last)
    else $error("chunk end flagged on a non-final word");
`endif

endmodule

/* rtl/core/brd_front.sv */
// ----------------------------------------------------------------------------
// brd_front
// Header parser: tracks the group state, checks the output limit and issues
// one command per byte that produces output or ends a chunk.
// ----------------------------------------------------------------------------
module brd_front import brd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  brd_in_t           in_data_i,
  input  logic [LimitW-1:0] limit_i,
  output logic              push_o,
  output brd_cmd_t          cmd_o
);

  typedef enum logic [3:0] {
    PhHeader  = 4'b0001,
    PhLiteral = 4'b0010,
    PhRun     = 4'b0100,
    PhDrop    = 4'b1000
  } brd_phase_e;

  brd_phase_e        phase_q, phase_d;
  logic [6:0]        grp_q, grp_d;
  logic [6:0]        run_q, run_d;
  logic [LimitW-1:0] left_q, left_d;
  logic              err_q, err_d;

  logic [7:0] b;
  logic [7:0] n;
  logic       over;
  logic       push;
  logic [LenW-1:0] len;

  assign b    = in_data_i.in_byte;
  assign n    = b[7] ? (8'd0 - b) : (b + 8'd1);
  assign over = LimitW'(n) > left_q;

  always_comb begin
    phase_d = phase_q;
    grp_d   = grp_q;
    run_d   = run_q;
    left_d  = left_q;
    err_d   = err_q;
    push    = 1'b0;
    len     = '0;
    unique case (phase_q)
      PhHeader: begin
        if (over) begin
          err_d   = 1'b1;
          phase_d = PhDrop;
        end else begin
          left_d = left_q - LimitW'(n);
          if (b[7]) begin
            grp_d   = 7'(n - 8'd1);
            phase_d = PhLiteral;
          end else begin
            run_d   = b[6:0];
            phase_d = PhRun;
          end
          if (in_data_i.in_last) begin
            err_d   = 1'b1;
            phase_d = PhDrop;
          end
        end
      end
      PhLiteral: begin
        if (in_data_i.in_last && grp_q != 7'd0) begin
          err_d = 1'b1;
        end
        push = 1'b1;
        len  = LenW'(1);
        if (grp_q == 7'd0) begin
          phase_d = PhHeader;
        end else begin
          grp_d = grp_q - 7'd1;
        end
      end
      PhRun: begin
        push    = 1'b1;
        len     = {1'b0, run_q} + LenW'(1);
        phase_d = PhHeader;
      end
      PhDrop: begin
        push = 1'b0;
      end
      default: begin
        phase_d = PhHeader;
      end
    endcase
  end

  always_comb begin
    cmd_o.data_byte = b;
    cmd_o.len       = len;
    cmd_o.last      = in_data_i.in_last;
    cmd_o.status    = err_d;
    push_o          = accept_i && (push || in_data_i.in_last);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHeader;
      grp_q   <= '0;
      run_q   <= '0;
      left_q  <= LimitReset;
      err_q   <= 1'b0;
    end else if (accept_i) begin
      if (in_data_i.in_last) begin
        phase_q <= PhHeader;
        grp_q   <= '0;
        run_q   <= '0;
        left_q  <= limit_i;
        err_q   <= 1'b0;
      end else begin
        phase_q <= phase_d;
        grp_q   <= grp_d;
        run_q   <= run_d;
        left_q  <= left_d;
        err_q   <= err_d;
      end
    end
  end

endmodule

/* rtl/core/brd_queue.sv */
// ----------------------------------------------------------------------------
// brd_queue
// Small register FIFO between the parser and the expander.
// ----------------------------------------------------------------------------
module brd_queue #(
  parameter int unsigned DataW = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [DataW-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [DataW-1:0] data_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  logic [DataW-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o  = cnt_q == CntW'(Depth);
  assign empty_o = cnt_q == '0;
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

/* rtl/core/brd_back.sv */
// ----------------------------------------------------------------------------
// brd_back
// Expander: turns each command into output words of up to four bytes and
// holds them in the output register.
// ----------------------------------------------------------------------------
module brd_back import brd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cmd_valid_i,
  input  brd_cmd_t cmd_i,
  output logic     pop_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output brd_out_t out_data_o
);

  logic [LenW-1:0]   sent_q;
  logic [LenW-1:0]   remaining;
  logic              fin;
  logic              adv;
  logic [CountW-1:0] cnt;
  logic [WordW-1:0]  word;
  logic              out_valid_q;
  brd_out_t          out_q, out_d;

  assign adv       = !out_valid_q || !out_stall_i;
  assign remaining = cmd_i.len - sent_q;
  assign fin       = remaining <= LenW'(BytesPerResult);
  assign cnt       = fin ? CountW'(remaining) : CountW'(BytesPerResult);
  assign pop_o     = adv && cmd_valid_i && fin;

  always_comb begin
    for (int i = 0; i < BytesPerResult; i++) begin
      word[8*i +: 8] = (CountW'(i) < cnt) ? cmd_i.data_byte : 8'd0;
    end
    out_d.out_word   = word;
    out_d.out_count  = cnt;
    out_d.item_last  = fin;
    out_d.chunk_done = fin && cmd_i.last;
    out_d.status     = cmd_i.status;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sent_q      <= '0;
    end else if (adv) begin
      out_valid_q <= cmd_valid_i;
      if (cmd_valid_i) begin
        sent_q <= fin ? '0 : sent_q + LenW'(BytesPerResult);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && cmd_valid_i) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* sim/brd_decode_checker.sv */
// ----------------------------------------------------------------------------
// brd_decode_checker
// Watches the byte, result and limit channels of the run-length decoder,
// decodes every accepted byte on its own copy of the decoder state and
// compares each accepted result word with the oldest decoded word waiting.
// ----------------------------------------------------------------------------
module brd_decode_checker import brd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  brd_in_t           in_data_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  brd_out_t          out_data_i,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [LimitW-1:0] cfg_data_i,
  output int                pending_o,
  output int                fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {
    WaitHeader,
    InLiteral,
    InRun,
    Dropping
  } decode_phase_e;

  decode_phase_e     phase_q;
  logic [6:0]        group_left_q;
  logic [7:0]        run_len_q;
  logic [LimitW-1:0] bytes_left_q;
  logic              bad_chunk_q;
  logic [LimitW-1:0] limit_q;

  brd_out_t decoded_q[$];
  brd_out_t step_q[$];

  initial fail_count_o = 0;

  function automatic void start_chunk();
    phase_q      = WaitHeader;
    group_left_q = '0;
    run_len_q    = '0;
    bytes_left_q = limit_q;
    bad_chunk_q  = 1'b0;
  endfunction

  function automatic void emit(input logic [WordW-1:0] word, input logic [CountW-1:0] cnt);
    brd_out_t r;
    r           = '0;
    r.out_word  = word;
    r.out_count = cnt;
    r.status    = bad_chunk_q;
    step_q.push_back(r);
  endfunction

  function automatic void decode_word(input brd_in_t w);
    int unsigned      n;
    int unsigned      left;
    int unsigned      cnt;
    logic [WordW-1:0] word;
    brd_out_t         r;
    step_q.delete();
    case (phase_q)
      WaitHeader: begin
        n = w.in_byte[7] ? 256 - w.in_byte : w.in_byte + 1;
        if (n > bytes_left_q) begin
          bad_chunk_q = 1'b1;
          phase_q     = Dropping;
        end else begin
          bytes_left_q = bytes_left_q - LimitW'(n);
          if (w.in_byte[7]) begin
            group_left_q = 7'(n - 1);
            phase_q      = InLiteral;
          end else begin
            run_len_q = w.in_byte;
            phase_q   = InRun;
          end
          if (w.in_last) begin
            bad_chunk_q = 1'b1;
            phase_q     = Dropping;
          end
        end
      end
      InLiteral: begin
        if (w.in_last && group_left_q != 0) bad_chunk_q = 1'b1;
        emit(WordW'(w.in_byte), CountW'(1));
        if (group_left_q == 0) phase_q = WaitHeader;
        else group_left_q = group_left_q - 7'd1;
      end
      InRun: begin
        left = run_len_q[6:0] + 1;
        while (left > 0) begin
          cnt  = (left < BytesPerResult) ? left : BytesPerResult;
          word = '0;
          for (int i = 0; i < cnt; i++) word[8*i +: 8] = w.in_byte;
          emit(word, CountW'(cnt));
          left -= cnt;
        end
        phase_q = WaitHeader;
      end
      default: ;
    endcase
    if (w.in_last) begin
      if (step_q.size() == 0) emit('0, '0);
      r            = step_q.pop_back();
      r.chunk_done = 1'b1;
      step_q.push_back(r);
      start_chunk();
    end
    if (step_q.size() > 0) begin
      r           = step_q.pop_back();
      r.item_last = 1'b1;
      step_q.push_back(r);
    end
    foreach (step_q[i]) decoded_q.push_back(step_q[i]);
  endfunction

  task automatic report_mismatch(input string what, input brd_out_t got, input brd_out_t want);
    fail_count_o++;
    if (fail_count_o <= 50)
      $display("[%0t] %s: got word=%h cnt=%0d il=%b cd=%b st=%b want word=%h cnt=%0d il=%b cd=%b st=%b",
               $time, what, got.out_word, got.out_count, got.item_last, got.chunk_done,
               got.status, want.out_word, want.out_count, want.item_last, want.chunk_done,
               want.status);
  endtask

  task automatic check_result(input brd_out_t got);
    brd_out_t want;
    if (decoded_q.size() == 0) begin
      report_mismatch("unexpected word", got, '0);
    end else begin
      want = decoded_q.pop_front();
      if (got.out_word !== want.out_word || got.out_count !== want.out_count ||
          got.item_last !== want.item_last || got.chunk_done !== want.chunk_done ||
          got.status !== want.status)
        report_mismatch("word mismatch", got, want);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q = LimitReset;
      start_chunk();
      decoded_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) limit_q = cfg_data_i;
      if (in_valid_i && !in_stall_i) decode_word(in_data_i);
      if (out_valid_i && !out_stall_i) check_result(out_data_i);
      pending_o <= decoded_q.size();
    end
  end

endmodule

/* sim/byte_rle_decoder_test.sv */
// ----------------------------------------------------------------------------
// byte_rle_decoder_test
// Drives compressed chunks into the run-length decoder: a directed set of
// runs, literals, truncations and limit overruns, then random chunks over
// several output limits and idle/stall patterns, including a long output
// hold-off. The checker beside the block decides on every result word.
// ----------------------------------------------------------------------------
module byte_rle_decoder_test;
  import brd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HoldOffCycles = 300;
  localparam int WatchdogLimit = 4000;
  localparam int NumPhases     = 6;
  localparam int PhaseWords    = 34;

  logic              clk_i;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  brd_in_t           in_data_i   = '0;
  logic              out_stall_i = 1'b0;
  logic              cfg_valid_i = 1'b0;
  logic [LimitW-1:0] cfg_data_i  = '0;
  logic              in_stall_o;
  logic              out_valid_o;
  brd_out_t          out_data_o;
  logic              cfg_ready_o;

  int pending;
  int fail_count;
  int idle_pct      = 0;
  int stall_pct     = 0;
  int hold_off_reqs = 0;
  int hold_off_done = 0;
  int words_sent    = 0;
  int quiet_cycles  = 0;

  logic [7:0] chunk_bytes[$];

  byte_rle_decoder u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  brd_decode_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_i   (out_data_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("FAIL byte_rle_decoder");
        $finish;
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_off_done != hold_off_reqs) begin
        out_stall_i <= 1'b1;
        repeat (HoldOffCycles - 1) @(posedge clk_i);
        hold_off_done++;
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  task automatic send_word(input brd_in_t w);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    words_sent++;
  endtask

  task automatic send_chunk();
    brd_in_t w;
    foreach (chunk_bytes[i]) begin
      w.in_byte = chunk_bytes[i];
      w.in_last = (i == chunk_bytes.size() - 1);
      send_word(w);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [LimitW-1:0] value);
    wait_drained();
    repeat (8) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic void add_group();
    int unsigned n;
    if ($urandom_range(1) == 1) begin
      n = ($urandom_range(15) == 0) ? $urandom_range(100, 128) : $urandom_range(1, 8);
      chunk_bytes.push_back(8'(256 - n));
      repeat (n) chunk_bytes.push_back(8'($urandom));
    end else begin
      chunk_bytes.push_back(($urandom_range(7) == 0) ? 8'($urandom_range(100, 127))
                                                     : 8'($urandom_range(0, 15)));
      chunk_bytes.push_back(8'($urandom));
    end
  endfunction

  // mostly well-formed chunks, some cut short, some pure noise
  function automatic void build_chunk();
    int unsigned kind;
    int unsigned keep;
    chunk_bytes.delete();
    kind = $urandom_range(99);
    if (kind < 15) begin
      repeat ($urandom_range(1, 6)) chunk_bytes.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(1, 4)) add_group();
      if (kind < 30) begin
        keep = $urandom_range(1, chunk_bytes.size());
        while (chunk_bytes.size() > keep) void'(chunk_bytes.pop_back());
      end
    end
  endfunction

  initial begin
    int target;
    int chunk_no;
    logic [LimitW-1:0] limit;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    idle_pct  = 31;
    stall_pct = 31;
    chunk_bytes = '{8'h00, 8'hFF};
    send_chunk();
    chunk_bytes = '{8'h7F, 8'hA5};
    send_chunk();
    chunk_bytes = '{8'hFF, 8'h00};
    send_chunk();
    chunk_bytes = '{8'hFE, 8'h12, 8'h34, 8'h02, 8'h80};
    send_chunk();
    chunk_bytes = '{8'h05};
    send_chunk();
    chunk_bytes = '{8'hFC, 8'h11, 8'h22};
    send_chunk();
    chunk_bytes = '{8'h80, 8'h7E};
    send_chunk();
    write_limit(LimitW'(4));
    chunk_bytes = '{8'hFD, 8'h01, 8'h02, 8'h03, 8'h00, 8'h09};
    send_chunk();
    chunk_bytes = '{8'h04, 8'h44, 8'h01, 8'h55};
    send_chunk();

    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: begin limit = LimitReset;                          idle_pct = 0;  stall_pct = 0;  end
        1: begin limit = '0;                                  idle_pct = 74; stall_pct = 0;  end
        2: begin limit = LimitW'($urandom_range(8, 40));      idle_pct = 0;  stall_pct = 74; end
        3: begin limit = LimitW'(1);                          idle_pct = 31; stall_pct = 31; end
        4: begin limit = LimitW'($urandom_range(4096, 'hFFFFFF)); idle_pct = 0; stall_pct = 0; end
        default: begin limit = LimitW'($urandom_range(20, 60)); idle_pct = 31; stall_pct = 31; end
      endcase
      write_limit(limit);
      target   = words_sent + PhaseWords;
      chunk_no = 0;
      while (words_sent < target || (ph == 4 && chunk_no < 2)) begin
        if (ph == 4 && chunk_no == 1) begin
          // hold the output while long runs pile up behind it
          hold_off_reqs++;
          chunk_bytes = '{8'h7F, 8'h01, 8'h7F, 8'h02, 8'h7F, 8'h03, 8'h7F, 8'h04};
        end else begin
          build_chunk();
        end
        send_chunk();
        chunk_no++;
        if ($urandom_range(7) == 0) wait_drained();
      end
    end

    wait_drained();
    repeat (40) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS byte_rle_decoder");
    end else begin
      $display("FAIL byte_rle_decoder");
    end
    $finish;
  end

endmodule
